// ----- hdl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Types, constants and Q16.16 arithmetic helpers for the quaternion rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int FX_W   = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * FX_W;
	localparam int RND_W  = PROD_W - FRAC_W;
	localparam int N_PROD = 12;
	localparam int N_AXIS = 3;

	localparam logic [FX_W-1:0]   FX_MIN   = {1'b1, {(FX_W-1){1'b0}}};
	localparam logic [FX_W-1:0]   FX_MAX   = {1'b0, {(FX_W-1){1'b1}}};
	localparam logic [FX_W-1:0]   FX_ZERO  = '0;
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

	typedef logic [FX_W-1:0] fx_t;

	// value with its overflow mark
	typedef struct packed {
		logic ov;
		fx_t  val;
	} fx_res_t;

	// sign and magnitude of an unrounded product
	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] mag;
	} prod_t;

	typedef struct packed {
		fx_t x;
		fx_t y;
		fx_t z;
		fx_t w;
	} quat_t;

	function automatic prod_t fx_mul_raw(input fx_t a, input fx_t b);
		fx_t   ma;
		fx_t   mb;
		prod_t r;
		ma = a[FX_W-1] ? (FX_ZERO - a) : a;
		mb = b[FX_W-1] ? (FX_ZERO - b) : b;
		r.neg = a[FX_W-1] ^ b[FX_W-1];
		r.mag = PROD_W'(ma) * PROD_W'(mb);
		return r;
	endfunction

	// round to nearest (ties away from zero), drop the fraction, saturate to marker
	function automatic fx_res_t fx_round(input prod_t p);
		logic [PROD_W-1:0] sum;
		logic [RND_W-1:0]  rm;
		fx_res_t           r;
		sum = p.mag + RND_HALF;
		rm  = sum[PROD_W-1:FRAC_W];
		r.ov  = 1'b0;
		r.val = rm[FX_W-1:0];
		if (p.neg) begin
			if (rm > RND_W'(FX_MIN)) begin
				r.ov  = 1'b1;
				r.val = FX_MIN;
			end else begin
				r.val = FX_ZERO - rm[FX_W-1:0];
			end
		end else if (rm > RND_W'(FX_MAX)) begin
			r.ov  = 1'b1;
			r.val = FX_MIN;
		end
		return r;
	endfunction

	function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
		fx_t     s;
		fx_res_t r;
		s = a + b;
		r.ov  = ~(a[FX_W-1] ^ b[FX_W-1]) & (a[FX_W-1] ^ s[FX_W-1]);
		r.val = r.ov ? FX_MIN : s;
		return r;
	endfunction

	function automatic fx_res_t fx_sub(input fx_t a, input fx_t b);
		fx_t     d;
		fx_res_t r;
		d = a - b;
		r.ov  = (a[FX_W-1] ^ b[FX_W-1]) & (a[FX_W-1] ^ d[FX_W-1]);
		r.val = r.ov ? FX_MIN : d;
		return r;
	endfunction

	function automatic fx_res_t fx_neg(input fx_t a);
		fx_res_t r;
		r.ov  = (a == FX_MIN);
		r.val = r.ov ? FX_MIN : (FX_ZERO - a);
		return r;
	endfunction

endpackage

// ----- hdl/quaternion_vector_rotate_q16_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_q16_core
// Rotates a Q16.16 3-vector by a quaternion as q * (v,0) * conj(q).
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one request: quaternion (x,y,z,w) and the vector
//   (x,y,z), all signed Q16.16. Master channel returns the rotated vector and
//   an overflow flag that is set when any multiply, add, subtract or the
//   conjugate negation saturated on the way.
//   Ten register stages, passed in order by each request:
//   one stage for input and conjugate, then for each Hamilton product one
//   multiply stage, one rounding stage and the add tree stages.
//   Throughput is one request per cycle while the receiver does not stall; every stage holds its own valid bit
//   and loads whenever it is empty or its successor moves, so bubbles close
//   up and a request can enter while a finished result waits.
//   When the receiver stalls, the output stage holds its result and the stall
//   backs up stage by stage; s_axis_tready drops only once all ten stages hold
//   requests. Nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   The quaternion is not normalized; a non-unit one scales the vector.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_q16_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (32 bits each, lowest first)
	input  logic [223:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rot_x, rot_y, rot_z (32 bits each, lowest first)
	output logic [95:0]  m_axis_tdata,
	// overflow
	output logic        m_axis_tuser
);

	localparam int FX_W   = qvr_pkg::FX_W;
	localparam int N_PROD = qvr_pkg::N_PROD;
	localparam int N_AXIS = qvr_pkg::N_AXIS;
	localparam int NSTG   = 10;

	logic [NSTG:1] vld;
	logic [NSTG:1] en;

	// stage registers
	qvr_pkg::quat_t  q_s1;
	qvr_pkg::fx_t    px_s1, py_s1, pz_s1;
	qvr_pkg::quat_t  c_s1;
	logic            ov_s1;

	qvr_pkg::prod_t  pa_s2 [N_PROD];
	qvr_pkg::quat_t  c_s2;
	logic            ov_s2;

	qvr_pkg::fx_t    ma_s3 [N_PROD];
	qvr_pkg::quat_t  c_s3;
	logic            ov_s3;

	qvr_pkg::fx_t    ta_s4 [N_AXIS];
	qvr_pkg::fx_t    td_s4 [N_AXIS];
	qvr_pkg::fx_t    w1_s4;
	qvr_pkg::fx_t    wy_s4, wz_s4;
	qvr_pkg::quat_t  c_s4;
	logic            ov_s4;

	qvr_pkg::fx_t    t_s5 [N_AXIS];
	qvr_pkg::fx_t    w2_s5;
	qvr_pkg::fx_t    wz_s5;
	qvr_pkg::quat_t  c_s5;
	logic            ov_s5;

	qvr_pkg::quat_t  t_s6;
	qvr_pkg::quat_t  c_s6;
	logic            ov_s6;

	qvr_pkg::prod_t  pb_s7 [N_PROD];
	logic            ov_s7;

	qvr_pkg::fx_t    mb_s8 [N_PROD];
	logic            ov_s8;

	qvr_pkg::fx_t    bs_s9 [N_AXIS];
	qvr_pkg::fx_t    bd_s9 [N_AXIS];
	logic            ov_s9;

	qvr_pkg::fx_t    rot_s10 [N_AXIS];
	logic            ov_s10;

	// next-state values
	qvr_pkg::quat_t   q_in;
	qvr_pkg::fx_t     px_in, py_in, pz_in;
	qvr_pkg::fx_res_t nx_d, ny_d, nz_d;
	qvr_pkg::fx_res_t ma_d [N_PROD];
	logic             ov3_d;
	qvr_pkg::fx_res_t td_d [N_AXIS];
	qvr_pkg::fx_res_t w1_d;
	qvr_pkg::fx_res_t t5_d [N_AXIS];
	qvr_pkg::fx_res_t w2_d;
	qvr_pkg::fx_res_t w3_d;
	qvr_pkg::fx_res_t mb_d [N_PROD];
	logic             ov8_d;
	qvr_pkg::fx_res_t bs_d [N_AXIS];
	qvr_pkg::fx_res_t bd_d [N_AXIS];
	qvr_pkg::fx_res_t rot_d [N_AXIS];

	// ---------------- handshake ----------------
	always_comb begin
		en[NSTG] = !vld[NSTG] || m_axis_tready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (en[i]) begin
					vld[i] <= vld[i-1];
				end
			end
		end
	end

	// ---------------- stage 1: unpack, conjugate ----------------
	always_comb begin
		q_in.x = s_axis_tdata[0*FX_W +: FX_W];
		q_in.y = s_axis_tdata[1*FX_W +: FX_W];
		q_in.z = s_axis_tdata[2*FX_W +: FX_W];
		q_in.w = s_axis_tdata[3*FX_W +: FX_W];
		px_in  = s_axis_tdata[4*FX_W +: FX_W];
		py_in  = s_axis_tdata[5*FX_W +: FX_W];
		pz_in  = s_axis_tdata[6*FX_W +: FX_W];
		nx_d   = qvr_pkg::fx_neg(q_in.x);
		ny_d   = qvr_pkg::fx_neg(q_in.y);
		nz_d   = qvr_pkg::fx_neg(q_in.z);
	end

	// ---------------- stage 3: round first products ----------------
	always_comb begin
		ov3_d = ov_s2;
		for (int k = 0; k < N_PROD; k++) begin
			ma_d[k] = qvr_pkg::fx_round(pa_s2[k]);
			ov3_d   = ov3_d | ma_d[k].ov;
		end
	end

	// ---------------- stages 4..6: first add tree ----------------
	// The pure quaternion has w = 0, so the terms with p.w vanish exactly.
	always_comb begin
		for (int k = 0; k < N_AXIS; k++) begin
			td_d[k] = qvr_pkg::fx_sub(ma_s3[3*k+1], ma_s3[3*k+2]);
			t5_d[k] = qvr_pkg::fx_add(ta_s4[k], td_s4[k]);
		end
		w1_d = qvr_pkg::fx_sub(qvr_pkg::FX_ZERO, ma_s3[9]);
		w2_d = qvr_pkg::fx_sub(w1_s4, wy_s4);
		w3_d = qvr_pkg::fx_sub(w2_s5, wz_s5);
	end

	// ---------------- stages 8..10: round and second add tree ----------------
	always_comb begin
		ov8_d = ov_s7;
		for (int k = 0; k < N_PROD; k++) begin
			mb_d[k] = qvr_pkg::fx_round(pb_s7[k]);
			ov8_d   = ov8_d | mb_d[k].ov;
		end
		for (int k = 0; k < N_AXIS; k++) begin
			bs_d[k]  = qvr_pkg::fx_add(mb_s8[4*k],   mb_s8[4*k+1]);
			bd_d[k]  = qvr_pkg::fx_sub(mb_s8[4*k+2], mb_s8[4*k+3]);
			rot_d[k] = qvr_pkg::fx_add(bs_s9[k], bd_s9[k]);
		end
	end

	// ---------------- data path registers ----------------
	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s1   <= q_in;
			px_s1  <= px_in;
			py_s1  <= py_in;
			pz_s1  <= pz_in;
			c_s1.x <= nx_d.val;
			c_s1.y <= ny_d.val;
			c_s1.z <= nz_d.val;
			c_s1.w <= q_in.w;
			ov_s1  <= nx_d.ov | ny_d.ov | nz_d.ov;
		end
		if (en[2]) begin
			pa_s2[0]  <= qvr_pkg::fx_mul_raw(q_s1.w, px_s1);
			pa_s2[1]  <= qvr_pkg::fx_mul_raw(q_s1.y, pz_s1);
			pa_s2[2]  <= qvr_pkg::fx_mul_raw(q_s1.z, py_s1);
			pa_s2[3]  <= qvr_pkg::fx_mul_raw(q_s1.w, py_s1);
			pa_s2[4]  <= qvr_pkg::fx_mul_raw(q_s1.z, px_s1);
			pa_s2[5]  <= qvr_pkg::fx_mul_raw(q_s1.x, pz_s1);
			pa_s2[6]  <= qvr_pkg::fx_mul_raw(q_s1.w, pz_s1);
			pa_s2[7]  <= qvr_pkg::fx_mul_raw(q_s1.x, py_s1);
			pa_s2[8]  <= qvr_pkg::fx_mul_raw(q_s1.y, px_s1);
			pa_s2[9]  <= qvr_pkg::fx_mul_raw(q_s1.x, px_s1);
			pa_s2[10] <= qvr_pkg::fx_mul_raw(q_s1.y, py_s1);
			pa_s2[11] <= qvr_pkg::fx_mul_raw(q_s1.z, pz_s1);
			c_s2      <= c_s1;
			ov_s2     <= ov_s1;
		end
		if (en[3]) begin
			for (int k = 0; k < N_PROD; k++) begin
				ma_s3[k] <= ma_d[k].val;
			end
			c_s3  <= c_s2;
			ov_s3 <= ov3_d;
		end
		if (en[4]) begin
			for (int k = 0; k < N_AXIS; k++) begin
				ta_s4[k] <= ma_s3[3*k];
				td_s4[k] <= td_d[k].val;
			end
			w1_s4 <= w1_d.val;
			wy_s4 <= ma_s3[10];
			wz_s4 <= ma_s3[11];
			c_s4  <= c_s3;
			ov_s4 <= ov_s3 | td_d[0].ov | td_d[1].ov | td_d[2].ov | w1_d.ov;
		end
		if (en[5]) begin
			for (int k = 0; k < N_AXIS; k++) begin
				t_s5[k] <= t5_d[k].val;
			end
			w2_s5 <= w2_d.val;
			wz_s5 <= wz_s4;
			c_s5  <= c_s4;
			ov_s5 <= ov_s4 | t5_d[0].ov | t5_d[1].ov | t5_d[2].ov | w2_d.ov;
		end
		if (en[6]) begin
			t_s6.x <= t_s5[0];
			t_s6.y <= t_s5[1];
			t_s6.z <= t_s5[2];
			t_s6.w <= w3_d.val;
			c_s6   <= c_s5;
			ov_s6  <= ov_s5 | w3_d.ov;
		end
		if (en[7]) begin
			pb_s7[0]  <= qvr_pkg::fx_mul_raw(t_s6.w, c_s6.x);
			pb_s7[1]  <= qvr_pkg::fx_mul_raw(t_s6.x, c_s6.w);
			pb_s7[2]  <= qvr_pkg::fx_mul_raw(t_s6.y, c_s6.z);
			pb_s7[3]  <= qvr_pkg::fx_mul_raw(t_s6.z, c_s6.y);
			pb_s7[4]  <= qvr_pkg::fx_mul_raw(t_s6.w, c_s6.y);
			pb_s7[5]  <= qvr_pkg::fx_mul_raw(t_s6.y, c_s6.w);
			pb_s7[6]  <= qvr_pkg::fx_mul_raw(t_s6.z, c_s6.x);
			pb_s7[7]  <= qvr_pkg::fx_mul_raw(t_s6.x, c_s6.z);
			pb_s7[8]  <= qvr_pkg::fx_mul_raw(t_s6.w, c_s6.z);
			pb_s7[9]  <= qvr_pkg::fx_mul_raw(t_s6.z, c_s6.w);
			pb_s7[10] <= qvr_pkg::fx_mul_raw(t_s6.x, c_s6.y);
			pb_s7[11] <= qvr_pkg::fx_mul_raw(t_s6.y, c_s6.x);
			ov_s7     <= ov_s6;
		end
		if (en[8]) begin
			for (int k = 0; k < N_PROD; k++) begin
				mb_s8[k] <= mb_d[k].val;
			end
			ov_s8 <= ov8_d;
		end
		if (en[9]) begin
			for (int k = 0; k < N_AXIS; k++) begin
				bs_s9[k] <= bs_d[k].val;
				bd_s9[k] <= bd_d[k].val;
			end
			ov_s9 <= ov_s8 | bs_d[0].ov | bs_d[1].ov | bs_d[2].ov
				| bd_d[0].ov | bd_d[1].ov | bd_d[2].ov;
		end
		if (en[10]) begin
			for (int k = 0; k < N_AXIS; k++) begin
				rot_s10[k] <= rot_d[k].val;
			end
			ov_s10 <= ov_s9 | rot_d[0].ov | rot_d[1].ov | rot_d[2].ov;
		end
	end

	assign m_axis_tdata = {rot_s10[2], rot_s10[1], rot_s10[0]};
	assign m_axis_tuser = ov_s10;

	// ---------------- assertions ----------------
	// an empty output stage means the whole pipe can take a request
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NSTG] |-> s_axis_tready)
		else $error("pipeline not ready with empty output stage");

	// conjugating the most negative x component must raise the flag
	a_conj_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[FX_W-1:0] == qvr_pkg::FX_MIN)
		|=> ov_s1)
		else $error("conjugate overflow not flagged");

	// a blocked stage keeps its request
	a_stage3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[3] && !en[3]) |=> vld[3] && $stable(ov_s3))
		else $error("stalled stage lost its request");

	// a stalled output backs up into the stage before it
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NSTG] && !m_axis_tready && vld[NSTG-1]) |=> vld[NSTG] && vld[NSTG-1])
		else $error("request dropped under output stall");

endmodule
